// ===== design/ett_pkg.sv =====
package ett_pkg;

  localparam int LaneCountDefault = 4;
  localparam int SineDepthDefault = 256;
  localparam int TimeBitsDefault  = 24;

  localparam logic [16:0] OneQ15 = 17'd32768;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_SEEK    = 2'd1,
    OP_KILL    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EASE_LINEAR   = 3'd0,
    EASE_SIN_IN   = 3'd1,
    EASE_SIN_OUT  = 3'd2,
    EASE_SIN_IO   = 3'd3,
    EASE_QUAD_IN  = 3'd4,
    EASE_QUAD_OUT = 3'd5,
    EASE_QUAD_IO  = 3'd6,
    EASE_LINEAR_B = 3'd7
  } ease_t;

  localparam logic [1:0] END_RUNNING = 2'd0;
  localparam logic [1:0] END_DONE    = 2'd1;
  localparam logic [1:0] END_STOP    = 2'd2;

  localparam logic [2:0] REG_DELAY    = 3'd0;
  localparam logic [2:0] REG_DURATION = 3'd1;
  localparam logic [2:0] REG_STOP     = 3'd2;
  localparam logic [2:0] REG_REPEAT   = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;
  localparam logic [2:0] REG_SCALE    = 3'd5;
  localparam logic [2:0] REG_START    = 3'd6;
  localparam logic [2:0] REG_END      = 3'd7;

  // Unsigned quotient by shift and subtract; elaboration-time use only.
  function automatic longint unsigned const_udiv(input longint unsigned n,
                                                 input longint unsigned d);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // Quarter-wave sine entry k of a table of the given depth, Q1.15.
  // Evaluated only at elaboration (constant table build).
  function automatic logic [15:0] sine_entry(input int k, input int depth);
    longint unsigned th, u, h, s;
    longint unsigned divs[5];
    divs[0] = 110; divs[1] = 72; divs[2] = 42; divs[3] = 20; divs[4] = 6;
    th = const_udiv(longint'(k) * 64'd1686629713 + longint'(depth >> 1), longint'(depth));
    u = (th * th) >> 30;
    h = 64'd1 << 30;
    for (int j = 0; j < 5; j++) begin
      h = (64'd1 << 30) - const_udiv((u * h) >> 30, divs[j]);
    end
    s = (((th * h) >> 30) + 64'd16384) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    return s[15:0];
  endfunction

endpackage

// ===== design/eased_tween_timeline.sv =====
// Tween timeline: one request in, one result out.
// Path from accept to result valid: S_DECIDE, then S_DONE when nothing is
// evaluated; zero duration skips the divider, no repeats takes one divider
// run and repeats take two; quad easings add the S_LANE_W state.
// Throughput: one request at a time; stall is high from accept to result taken,
// and the block returns to idle for the next request once the result is taken.
// Reset (rst, synchronous): registers take their defaults, the timeline clears.
module eased_tween_timeline import ett_pkg::*; #(
  parameter int LANE_COUNT       = LaneCountDefault,
  parameter int SINE_TABLE_DEPTH = SineDepthDefault,
  parameter int TIME_BITS        = TimeBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [23:0]        time_amount,
  input  logic               finish_on_kill,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] lane_value_0,
  output logic signed [15:0] lane_value_1,
  output logic signed [15:0] lane_value_2,
  output logic signed [15:0] lane_value_3,
  output logic [15:0]        eased_fraction,
  output logic [1:0]         end_status,
  output logic               start_event,
  output logic               update_event,
  output logic               complete_event,
  output logic               dead_flag
);
  localparam int SineBits = $clog2(SINE_TABLE_DEPTH);
  localparam int NumBits  = 48;

  // constant quarter-wave table
  logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, SINE_TABLE_DEPTH);
  end

  // configuration registers
  logic [TIME_BITS-1:0] delay_time, run_duration;
  logic signed [24:0]   stop_point;
  logic signed [16:0]   repeat_count;
  logic [4:0]           mode_bits;
  logic [15:0]          time_scale;
  logic [63:0]          start_values, end_values;

  // timeline state
  logic [31:0] elapsed_time;
  logic        started_flag, killed_flag;
  logic [1:0]  ended_code;
  logic [15:0] held_fraction;
  logic signed [15:0] held_lanes [4];

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_EVAL, S_DIV1, S_FOLD, S_DIV2, S_EASE_A, S_EASE_B,
    S_LANE_M, S_LANE_W, S_DONE, S_OUT
  } state_t;
  state_t state;

  logic [1:0]  op;
  logic [23:0] amt;
  logic        fin;
  logic        ev_start, ev_update, ev_complete;
  logic        kill_after; // advance: die if the tween ended
  logic [32:0] tt;         // time inside tween
  logic        rev;
  logic [16:0] xq;         // Q1.15 fraction
  logic [16:0] qv;         // eased
  logic [16:0] sarg;
  logic        sneg;       // ease post op selector
  logic [1:0]  lane;
  logic [39:0] mulp;

  // divider
  logic               div_start, div_done;
  logic [NumBits-1:0] div_num, div_quo;
  logic [TIME_BITS-1:0] div_rem;

  ett_div #(.NumBits(NumBits), .DenBits(TIME_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(run_duration),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  // sine lookup with interpolation (one table pair, one narrow multiply)
  logic [16:0] sx;
  logic [SineBits+15:0] sp_prod;
  logic [SineBits:0]    sidx;
  logic [14:0]          sfr;
  logic [15:0]          sa, sb, sd;
  logic [16:0]          sine_val;
  logic [31:0]          sine_mul;
  always_comb begin
    sx      = (sarg > OneQ15) ? OneQ15 : sarg;
    sp_prod = (SineBits+16)'(sx) * (SineBits+16)'(SINE_TABLE_DEPTH);
    sidx    = sp_prod[SineBits+15:15];
    sfr     = sp_prod[14:0];
    sa      = sine_rom[sidx];
    sb      = (sidx >= (SineBits+1)'(SINE_TABLE_DEPTH)) ? sa :
              sine_rom[sidx + 1'b1];
    sd      = (sb > sa) ? sb - sa : 16'd0;
    sine_mul = 32'(sd) * 32'(sfr) + 32'd16384;
    sine_val = (sidx >= (SineBits+1)'(SINE_TABLE_DEPTH)) ? {1'b0, sa} :
               17'(sa) + 17'(sine_mul[31:15]);
  end

  // decoded signed config
  logic signed [17:0] rep_eff;
  assign rep_eff = (repeat_count < -17'sd1) ? -18'sd1 : 18'(repeat_count);

  // time since the delay ran out; zero while still inside the delay
  logic [31:0] run_time;
  assign run_time = (elapsed_time >= 32'(delay_time)) ? elapsed_time - 32'(delay_time) : '0;

  // per-lane arithmetic on the shared multiplier
  logic signed [15:0] s_l, e_l;
  logic signed [16:0] diff;
  logic signed [34:0] prod;
  logic signed [19:0] rnd_q;
  logic signed [20:0] f_l;
  logic signed [15:0] f_sn;
  always_comb begin
    s_l   = start_values[lane*16 +: 16];
    e_l   = end_values[lane*16 +: 16];
    diff  = 17'(e_l) - 17'(s_l);
    prod  = 35'(diff) * $signed({18'd0, qv});
    rnd_q = 20'((prod + 35'sd16384) >>> 15);
    f_l   = 21'(s_l) + 21'(rnd_q);
    if (f_l >= 0) begin
      f_sn = ((f_l + 21'sd128) & ~21'sd255) > 21'sd32512 ? 16'sd32512 :
             16'((f_l + 21'sd128) & ~21'sd255);
    end else begin
      f_sn = 16'(-((-f_l + 21'sd128) & ~21'sd255));
    end
  end

  // kill end time
  logic [48:0] kill_e;
  always_comb begin
    if (!stop_point[24])
      kill_e = 49'(delay_time) + 49'(stop_point[23:0]);
    else if (rep_eff >= 0)
      kill_e = 49'(delay_time) + 49'(run_duration) * 49'(rep_eff[16:0] + 17'd1);
    else
      kill_e = 49'(delay_time) + (49'(run_duration) << 1);
  end

  logic [40:0] dt;
  logic [32:0] esum;
  assign dt   = (41'(amt) * 41'(time_scale)) >> 8;
  assign esum = 33'(elapsed_time) + 33'(dt[31:0]);

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      delay_time <= '0; run_duration <= '0; stop_point <= -25'sd1;
      repeat_count <= '0; mode_bits <= '0; time_scale <= 16'd256;
      start_values <= '0; end_values <= '0;
      elapsed_time <= '0; started_flag <= 1'b0; killed_flag <= 1'b0;
      ended_code <= END_RUNNING; held_fraction <= '0;
      for (int i = 0; i < 4; i++) held_lanes[i] <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_DELAY:    delay_time   <= TIME_BITS'(cfg_data[23:0]);
          REG_DURATION: run_duration <= TIME_BITS'(cfg_data[23:0]);
          REG_STOP:     stop_point   <= cfg_data[24:0];
          REG_REPEAT:   repeat_count <= cfg_data[16:0];
          REG_MODE:     mode_bits    <= cfg_data[4:0];
          REG_SCALE:    time_scale   <= cfg_data[15:0];
          REG_START:    start_values <= cfg_data;
          REG_END:      end_values   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          op <= opcode; amt <= 24'(TIME_BITS'(time_amount)); fin <= finish_on_kill;
          ev_start <= 1'b0; ev_update <= 1'b0; ev_complete <= 1'b0;
          kill_after <= 1'b0;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= S_DONE;
          if (!killed_flag) begin
            case (op)
              OP_ADVANCE: begin
                if (ended_code != END_RUNNING) begin
                  ev_complete <= 1'b1; killed_flag <= 1'b1;
                end else if (dt != 0) begin
                  elapsed_time <= (esum[32] || dt[40:32] != 0) ? '1 : esum[31:0];
                  kill_after <= 1'b1;
                  state <= S_EVAL;
                end
              end
              OP_SEEK: begin
                if (32'(amt) < 32'(delay_time)) begin
                  elapsed_time <= started_flag ? 32'(delay_time) : 32'(amt);
                  if (started_flag) state <= S_EVAL;
                end else begin
                  elapsed_time <= 32'(amt);
                  state <= S_EVAL;
                end
              end
              OP_KILL: begin
                killed_flag <= 1'b1;
                if (fin) begin
                  ev_complete <= 1'b1;
                  if (ended_code == END_RUNNING) begin
                    elapsed_time <= (kill_e[48:32] != 0) ? '1 : kill_e[31:0];
                    state <= S_EVAL;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_EVAL: begin
          ended_code <= END_RUNNING;
          rev <= 1'b0;
          if (!started_flag && elapsed_time < 32'(delay_time)) begin
            state <= S_DONE;
          end else begin
            if (!started_flag) begin
              started_flag <= 1'b1; ev_start <= 1'b1;
            end
            if (!stop_point[24] && run_time >= 32'(stop_point[23:0])) begin
              tt <= 33'(stop_point[23:0]);
              ended_code <= END_STOP;
            end else begin
              tt <= 33'(run_time);
            end
            if (run_duration == 0) begin
              ended_code <= END_DONE;
              qv <= '0;
              lane <= '0;
              state <= S_LANE_M;
            end else if (rep_eff != 0) begin
              state <= S_DIV1;
            end else begin
              state <= S_FOLD;
            end
          end
        end
        S_DIV1: begin
          div_num <= NumBits'(tt);
          div_start <= 1'b1;
          state <= S_FOLD;
        end
        S_FOLD: begin
          if (rep_eff == 0) begin
            if (tt >= 33'(run_duration)) begin
              tt <= 33'(run_duration); ended_code <= END_DONE;
            end
            state <= S_DIV2;
          end else if (div_done) begin
            tt  <= 33'(div_rem);
            rev <= mode_bits[3] & div_quo[0];
            if (rep_eff > 0 && div_quo > NumBits'(rep_eff[16:0])) begin
              rev <= mode_bits[3] & rep_eff[0];
              tt <= 33'(run_duration);
              ended_code <= END_DONE;
            end
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          div_num <= NumBits'(rev ? 33'(run_duration) - tt : tt) << 15;
          div_start <= 1'b1;
          state <= S_EASE_A;
        end
        S_EASE_A: if (div_done) begin
          xq <= div_quo[16:0];
          unique case (ease_t'(mode_bits[2:0]))
            EASE_SIN_IN:  begin sarg <= OneQ15 - div_quo[16:0]; end
            EASE_SIN_OUT: begin sarg <= div_quo[16:0]; end
            EASE_SIN_IO:  begin
              sarg <= (div_quo[16:0] <= 17'd16384) ? OneQ15 - (div_quo[16:0] << 1)
                                                   : (div_quo[16:0] << 1) - OneQ15;
            end
            EASE_QUAD_IN: begin sarg <= div_quo[16:0]; end
            EASE_QUAD_OUT: begin sarg <= OneQ15 - div_quo[16:0]; end
            EASE_QUAD_IO: begin
              sarg <= (div_quo[16:0] < 17'd16384) ? div_quo[16:0] : OneQ15 - div_quo[16:0];
            end
            default: sarg <= div_quo[16:0];
          endcase
          sneg <= div_quo[16:0] <= 17'd16384;
          state <= S_EASE_B;
        end
        S_EASE_B: begin
          mulp <= 40'(sarg) * 40'(sarg);
          state <= S_LANE_M;
          lane <= '0;
          unique case (ease_t'(mode_bits[2:0]))
            EASE_SIN_IN:  qv <= OneQ15 - sine_val;
            EASE_SIN_OUT: qv <= sine_val;
            EASE_SIN_IO:  qv <= sneg ? (OneQ15 - sine_val + 17'd1) >> 1
                                     : (OneQ15 + sine_val + 17'd1) >> 1;
            EASE_QUAD_IN, EASE_QUAD_OUT, EASE_QUAD_IO: state <= S_LANE_W;
            default:      qv <= xq;
          endcase
        end
        S_LANE_W: begin
          // quad finish from squared term
          unique case (ease_t'(mode_bits[2:0]))
            EASE_QUAD_IN:  qv <= 17'((mulp + 40'd16384) >> 15);
            EASE_QUAD_OUT: qv <= OneQ15 - 17'((mulp + 40'd16384) >> 15);
            default: qv <= (xq < 17'd16384) ? 17'((mulp + 40'd8192) >> 14)
                                             : OneQ15 - 17'((mulp + 40'd8192) >> 14);
          endcase
          state <= S_LANE_M;
        end
        S_LANE_M: begin
          held_fraction <= qv[15:0];
          if (32'(lane) < LANE_COUNT)
            held_lanes[lane] <= mode_bits[4] ? f_sn : 16'(f_l);
          else
            held_lanes[lane] <= '0;
          lane <= lane + 1'b1;
          if (lane == 2'd3) begin
            ev_update <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (kill_after && ended_code != END_RUNNING) begin
            ev_complete <= 1'b1; killed_flag <= 1'b1;
          end
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    lane_value_0   = held_lanes[0];
    lane_value_1   = held_lanes[1];
    lane_value_2   = held_lanes[2];
    lane_value_3   = held_lanes[3];
    eased_fraction = held_fraction;
    end_status     = ended_code;
    start_event    = ev_start;
    update_event   = ev_update;
    complete_event = ev_complete;
    dead_flag      = killed_flag;
  end
endmodule

// ===== design/ett_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ett_div import ett_pkg::*; #(
  parameter int NumBits = 48,
  parameter int DenBits = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NumBits-1:0] num,
  input  logic [DenBits-1:0] den,
  output logic               done,
  output logic [NumBits-1:0] quo,
  output logic [DenBits-1:0] rem
);
  localparam int CntBits = $clog2(NumBits + 1);

  logic               busy;
  logic [CntBits-1:0] cnt;
  logic [NumBits-1:0] shreg;
  logic [DenBits:0]   acc;
  logic [DenBits:0]   trial;
  logic [DenBits:0]   shifted;

  assign shifted = {acc[DenBits-1:0], shreg[NumBits-1]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= CntBits'(NumBits);
      shreg <= num;
      acc   <= '0;
    end else if (busy) begin
      if (!trial[DenBits]) begin
        acc   <= trial;
        shreg <= {shreg[NumBits-2:0], 1'b1};
      end else begin
        acc   <= shifted;
        shreg <= {shreg[NumBits-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntBits'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    quo = shreg;
    rem = acc[DenBits-1:0];
  end
endmodule
